### hdl/mpfb_pkg.sv
// ============================================================================
// mpfb_pkg
// Shared types, geometry constants and command codes of the page-addressed
// monochrome frame buffer.
// ============================================================================
package mpfb_pkg;

    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 64;
    localparam int PAGES        = PANEL_HEIGHT / 8;
    localparam int STORE_BYTES  = PANEL_WIDTH * PAGES;
    localparam int CMD_BYTES    = 3;
    localparam int PAGE_SPAN    = CMD_BYTES + PANEL_WIDTH;

    localparam int COL_W  = $clog2(PANEL_WIDTH);
    localparam int PG_W   = $clog2(PAGES);
    localparam int ADDR_W = COL_W + PG_W;
    localparam int OFF_W  = $clog2(PAGE_SPAN);

    typedef logic [COL_W-1:0]  t_col;
    typedef logic [PG_W-1:0]   t_pg;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [OFF_W-1:0]  t_off;

    localparam t_col LAST_COL = COL_W'(PANEL_WIDTH - 1);
    localparam t_pg  LAST_PG  = PG_W'(PAGES - 1);
    localparam logic [5:0] LAST_ROW = 6'(PANEL_HEIGHT - 1);
    localparam t_off OFF_DATA = OFF_W'(CMD_BYTES);
    localparam t_off OFF_LAST = OFF_W'(PAGE_SPAN - 1);

    // command codes
    localparam logic [2:0] FN_POINT   = 3'd0;
    localparam logic [2:0] FN_FILL    = 3'd1;
    localparam logic [2:0] FN_OUTLINE = 3'd2;
    localparam logic [2:0] FN_CLEAR   = 3'd3;
    localparam logic [2:0] FN_BYTE    = 3'd4;
    localparam logic [2:0] FN_EMIT    = 3'd5;

    // refresh stream command bytes
    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LO    = 8'h02;
    localparam logic [7:0] CMD_COL_HI    = 8'h10;

    typedef struct packed {
        logic [2:0] func;
        logic [6:0] x;
        logic [5:0] y;
        logic [6:0] x_len;
        logic [5:0] y_len;
        logic       pixel_on;
        logic [7:0] data_byte;
        logic [2:0] page;
    } t_in_item;

    typedef struct packed {
        logic       is_data;
        logic [7:0] out_byte;
        logic       frame_last;
    } t_out_item;

    typedef struct packed {
        logic       en;
        t_addr      addr;
        logic [7:0] data;
    } t_wr_req;

    typedef struct packed {
        logic  en;
        t_addr addr;
    } t_rd_req;

    typedef struct packed {
        t_pg        pg;
        logic       edge_col;
        logic       outline;
        logic [5:0] lo;
        logic [6:0] hi;
    } t_mask_req;

endpackage

### hdl/mpfb_store.sv
// ============================================================================
// mpfb_store
// Frame store: one write port, one read port with registered read data.
// ============================================================================
module mpfb_store (
    input  logic             i_clk,
    input  mpfb_pkg::t_wr_req i_wr,
    input  mpfb_pkg::t_rd_req i_rd,
    output logic [7:0]       o_rd_data
);
    import mpfb_pkg::*;

    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        // hold read data until the next read
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/mpfb_merge.sv
// ============================================================================
// mpfb_merge
// Shared pixel unit: builds the row mask of one page byte and merges a mask
// into the old byte.
// ============================================================================
module mpfb_merge (
    input  mpfb_pkg::t_mask_req i_req,
    output logic [7:0]          o_mask,
    input  logic [7:0]          i_old,
    input  logic [7:0]          i_mask,
    input  logic                i_on,
    output logic [7:0]          o_new
);
    import mpfb_pkg::*;

    t_pg pg_rev;

    // page index counts from the bottom of the panel
    assign pg_rev = LAST_PG - i_req.pg;

    for (genvar g = 0; g < 8; g++) begin : gen_bit
        logic [5:0] row;
        logic       in_span;
        logic       on_line;

        // bit g holds row 8*pg_rev + 7 - g
        assign row     = {pg_rev, 3'(7 - g)};
        assign in_span = (row >= i_req.lo) && ({1'b0, row} <= i_req.hi);
        assign on_line = (row == i_req.lo) || ({1'b0, row} == i_req.hi);
        assign o_mask[g] = (i_req.outline && !i_req.edge_col) ? on_line : in_span;
    end

    assign o_new = i_on ? (i_old | i_mask) : (i_old & ~i_mask);

endmodule

### hdl/mpfb_seq.sv
// ============================================================================
// mpfb_seq
// Command sequencer: walks columns and pages of a shape through the shared
// pixel unit, sweeps the store on clear, and produces refresh stream items.
// ============================================================================
module mpfb_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  mpfb_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output mpfb_pkg::t_out_item o_item,
    output mpfb_pkg::t_wr_req   o_wr,
    output mpfb_pkg::t_rd_req   o_rd,
    input  logic [7:0]          i_rd_data,
    output mpfb_pkg::t_mask_req o_mask_req,
    input  logic [7:0]          i_mask,
    output logic [7:0]          o_merge_mask,
    output logic                o_merge_on,
    input  logic [7:0]          i_merged
);
    import mpfb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_RECT,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    t_state     r_state;
    t_col       r_col;
    t_pg        r_pg;
    t_col       r_x1;
    logic [7:0] r_x2;
    t_col       r_xend;
    t_pg        r_pg_lo;
    t_pg        r_pg_hi;
    logic [5:0] r_ylo;
    logic [6:0] r_yhi;
    logic       r_on;
    logic       r_outline;
    logic [7:0] r_fill;
    logic       r_b_valid;
    t_addr      r_b_addr;
    logic [7:0] r_b_mask;
    t_off       r_off;
    t_pg        r_rpg;
    logic       r_ov;
    t_out_item  r_out;

    logic       accept;
    logic       is_point;
    logic [6:0] n_xl;
    logic [5:0] n_yl;
    logic [7:0] n_x2;
    logic [6:0] n_yhi;
    t_col       n_xend;
    logic [5:0] n_ylim;
    t_pg        n_pg_lo;
    t_pg        n_pg_hi;
    t_addr      rect_addr;
    t_out_item  emit_item;
    logic       out_free;

    assign accept   = i_valid && (r_state == ST_IDLE);
    assign o_stall  = (r_state != ST_IDLE);
    assign out_free = !r_ov || !i_stall;

    // shape setup from the incoming item; a point is a 1x1 fill
    assign is_point = (i_item.func == FN_POINT);
    assign n_xl     = is_point ? 7'd0 : i_item.x_len;
    assign n_yl     = is_point ? 6'd0 : i_item.y_len;
    assign n_x2     = {1'b0, i_item.x} + {1'b0, n_xl};
    assign n_yhi    = {1'b0, i_item.y} + {1'b0, n_yl};
    assign n_xend   = (n_x2 > {1'b0, LAST_COL}) ? LAST_COL : n_x2[COL_W-1:0];
    assign n_ylim   = (n_yhi > {1'b0, LAST_ROW}) ? LAST_ROW : n_yhi[5:0];
    assign n_pg_lo  = LAST_PG - n_ylim[5:3];
    assign n_pg_hi  = LAST_PG - i_item.y[5:3];

    assign rect_addr = {r_col, r_pg};

    assign o_mask_req.pg       = r_pg;
    assign o_mask_req.edge_col = (r_col == r_x1) || ({1'b0, r_col} == r_x2);
    assign o_mask_req.outline  = r_outline;
    assign o_mask_req.lo       = r_ylo;
    assign o_mask_req.hi       = r_yhi;
    assign o_merge_mask        = r_b_mask;
    assign o_merge_on          = r_on;

    // write port: merge write-back, clear sweep, raw byte
    always_comb begin
        o_wr = '0;
        if (r_b_valid) begin
            o_wr.en   = 1'b1;
            o_wr.addr = r_b_addr;
            o_wr.data = i_merged;
        end else if (r_state == ST_FILL) begin
            o_wr.en   = 1'b1;
            o_wr.addr = rect_addr;
            o_wr.data = r_fill;
        end else if (accept && (i_item.func == FN_BYTE)) begin
            o_wr.en   = 1'b1;
            o_wr.addr = {i_item.x, i_item.page};
            o_wr.data = i_item.data_byte;
        end
    end

    // read port: shape bytes, refresh data bytes
    always_comb begin
        o_rd = '0;
        if (r_state == ST_RECT) begin
            o_rd.en   = 1'b1;
            o_rd.addr = rect_addr;
        end else if (accept && (i_item.func == FN_EMIT) && (r_off >= OFF_DATA)) begin
            o_rd.en   = 1'b1;
            o_rd.addr = {COL_W'(r_off - OFF_DATA), r_rpg};
        end
    end

    always_comb begin
        emit_item.is_data    = (r_off >= OFF_DATA);
        emit_item.frame_last = (r_rpg == LAST_PG) && (r_off == OFF_LAST);
        if (r_off == OFF_W'(0)) begin
            emit_item.out_byte = CMD_PAGE_BASE + {{(8-PG_W){1'b0}}, r_rpg};
        end else if (r_off == OFF_W'(1)) begin
            emit_item.out_byte = CMD_COL_LO;
        end else if (r_off == OFF_W'(2)) begin
            emit_item.out_byte = CMD_COL_HI;
        end else begin
            emit_item.out_byte = i_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_FILL;
            r_col     <= '0;
            r_pg      <= '0;
            r_fill    <= '0;
            r_b_valid <= 1'b0;
            r_off     <= '0;
            r_rpg     <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_b_valid <= (r_state == ST_RECT);
            r_b_addr  <= rect_addr;
            r_b_mask  <= i_mask;
            // load a result when leaving emit, drop it once taken
            if ((r_state == ST_EMIT) && out_free) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        case (i_item.func) inside
                            FN_POINT, FN_FILL, FN_OUTLINE: begin
                                r_x1      <= i_item.x;
                                r_x2      <= n_x2;
                                r_xend    <= n_xend;
                                r_ylo     <= i_item.y;
                                r_yhi     <= n_yhi;
                                r_pg_lo   <= n_pg_lo;
                                r_pg_hi   <= n_pg_hi;
                                r_on      <= i_item.pixel_on;
                                r_outline <= (i_item.func == FN_OUTLINE);
                                r_col     <= i_item.x;
                                r_pg      <= n_pg_lo;
                                r_state   <= ST_RECT;
                            end
                            FN_CLEAR: begin
                                r_fill  <= i_item.data_byte;
                                r_col   <= '0;
                                r_pg    <= '0;
                                r_state <= ST_FILL;
                            end
                            FN_EMIT: begin
                                r_state <= ST_EMIT;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_FILL: begin
                    if (r_pg == LAST_PG) begin
                        r_pg <= '0;
                        if (r_col == LAST_COL) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end else begin
                        r_pg <= r_pg + 1'b1;
                    end
                end
                ST_RECT: begin
                    if (r_pg == r_pg_hi) begin
                        r_pg <= r_pg_lo;
                        if (r_col == r_xend) begin
                            r_state <= ST_DRAIN;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end else begin
                        r_pg <= r_pg + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_IDLE;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out   <= emit_item;
                        r_state <= ST_IDLE;
                        if (r_off == OFF_LAST) begin
                            r_off <= '0;
                            r_rpg <= (r_rpg == LAST_PG) ? '0 : r_rpg + 1'b1;
                        end else begin
                            r_off <= r_off + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;

`ifndef SYNTHESIS
    // write-back of the previous byte never hits the byte being read
    a_no_rmw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RECT && r_b_valid) |-> (r_b_addr != rect_addr))
        else $error("shape write-back collides with read");

    // ready only with the write-back stage empty
    a_ready_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> !r_b_valid)
        else $error("ready while write-back pending");

    // the clearing pass holds off items right after reset
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (o_stall && r_state == ST_FILL))
        else $error("no clearing pass after reset");

    // a result is loaded only when leaving the emit state
    a_load_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_ov || !i_stall) && $past(r_state) != ST_EMIT && $past(i_rst_n)
            |-> !(r_ov && !$past(r_ov)))
        else $error("result without refresh command");
`endif

endmodule

### hdl/mono_page_frame_buffer_engine_unit.sv
// ============================================================================
// mono_page_frame_buffer_engine_unit
// Page-addressed 128x64 monochrome frame buffer with drawing commands and a
// refresh byte stream.
// ============================================================================
// Flow: an accepted refresh item holds o_stall high in the emit state, which
//   waits while an untaken result is held, then loads the o_valid register.
//   Byte write and unused codes keep the sequencer idle. Points and shapes
//   walk each column and touched page in the rectangle state, then drain;
//   the store's single read-modify-write path takes one page byte per cycle.
// Reset: synchronous, active low; a clearing pass then zeroes the 1024-byte
//   store with stall high, and the refresh position restarts.
module mono_page_frame_buffer_engine_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  mpfb_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output mpfb_pkg::t_out_item o_item
);
    import mpfb_pkg::*;

    t_wr_req    wr_req;
    t_rd_req    rd_req;
    logic [7:0] rd_data;
    t_mask_req  mask_req;
    logic [7:0] mask;
    logic [7:0] merge_mask;
    logic       merge_on;
    logic [7:0] merged;

    // sequencer: decode items, walk shapes, sweep, drive the stream
    mpfb_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_item       (i_item),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_item       (o_item),
        .o_wr         (wr_req),
        .o_rd         (rd_req),
        .i_rd_data    (rd_data),
        .o_mask_req   (mask_req),
        .i_mask       (mask),
        .o_merge_mask (merge_mask),
        .o_merge_on   (merge_on),
        .i_merged     (merged)
    );

    // shared pixel unit: mask for the byte being read, merge for write-back
    mpfb_merge u_merge (
        .i_req  (mask_req),
        .o_mask (mask),
        .i_old  (rd_data),
        .i_mask (merge_mask),
        .i_on   (merge_on),
        .o_new  (merged)
    );

    // frame store, column-major with 8 page bytes per column
    mpfb_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr_req),
        .i_rd      (rd_req),
        .o_rd_data (rd_data)
    );

endmodule
